>>> design/assert_macros.svh
// Assertion macros used by the lock table top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define LTW_ASSERT(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);
`define LTW_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`else
`define LTW_ASSERT(lbl, cond, msg)
`define LTW_ASSERT_IMPL(lbl, ante, cons, msg)
`endif
`endif

>>> design/ltw_pkg.sv
// Types and constants of the lock table with waiter queues.
package ltw_pkg;
  localparam int LOCK_MODES = 5;
  localparam int CLIENT_BITS = 8;
  localparam int MODE_W = 3;
  localparam int TIME_W = 48;
  localparam int EXP_W = 49;
  localparam int LEASE_W = 32;
  localparam int MAT_W = LOCK_MODES * LOCK_MODES;
  localparam int MIDX_W = $clog2(MAT_W);
  localparam int MAX_RESULTS = 8;

  typedef enum logic [2:0] {
    OP_CHECK = 3'd0,
    OP_GRANT = 3'd1,
    OP_RELEASE = 3'd2,
    OP_ADD_WAITER = 3'd3,
    OP_WAKE = 3'd4
  } op_t;

  typedef enum logic [1:0] {
    ST_OK = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_FULL = 2'd2
  } status_t;

  localparam logic REG_COMPAT = 1'b0;
  localparam logic REG_LEASE = 1'b1;

  typedef struct packed {
    logic [CLIENT_BITS-1:0] cli;
    logic [MODE_W-1:0] md;
    logic [EXP_W-1:0] expiry;
  } grant_entry_t;

  typedef struct packed {
    logic [CLIENT_BITS-1:0] cli;
    logic [MODE_W-1:0] md;
  } waiter_entry_t;

  typedef struct packed {
    logic [CLIENT_BITS-1:0] cli;
    logic [MODE_W-1:0] md;
    logic [TIME_W-1:0] now;
    logic [MAT_W-1:0] matrix;
  } conf_req_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_LK_RD,
    S_LK_CMP,
    S_CNT_RD,
    S_CNT,
    S_DISP,
    S_GR_RD,
    S_GR_CMP,
    S_REL_RD,
    S_REL_WR,
    S_WK_RD,
    S_WK_GET,
    S_WK_GRANT,
    S_WK_LAST_RD,
    S_WK_LAST_WR,
    S_FIN,
    S_EMIT
  } state_t;
endpackage

>>> design/ltw_conflict.sv
// Conflict test of one held grant against a lock request.
module ltw_conflict
  import ltw_pkg::*;
(
  input  grant_entry_t grant,
  input  conf_req_t    req,
  output logic         conflict
);
  logic same_client;
  logic expired;
  logic in_range;
  logic [MIDX_W-1:0] bit_idx;
  logic compat;

  assign same_client = grant.cli == req.cli;
  assign expired = (grant.expiry != '0) && ({1'b0, req.now} >= grant.expiry);
  assign in_range = (grant.md < MODE_W'(LOCK_MODES)) && (req.md < MODE_W'(LOCK_MODES));
  assign bit_idx = MIDX_W'(grant.md) * MIDX_W'(LOCK_MODES) + MIDX_W'(req.md);
  assign compat = in_range && req.matrix[bit_idx];
  assign conflict = !same_client && !expired && !compat;
endmodule

>>> design/lock_table_with_waiters_unit.sv
// Lock table with grant lists and waiter queues per node, top level.
//
//   channel   direction  handshake                  payload
//   input     in         in_valid / in_ready        mode node_key client lock_mode
//                                                    grant_lease now_ms
//   result    out        out_valid / out_ready      status conflict_free woken_valid
//                                                    woken_client woken_mode last
//   config    in         APB psel/penable/pwrite    paddr pwdata prdata pready
//
// Node lookup reads the key memory and compares each claimed slot in turn.
// Counts are read in S_CNT_RD and S_CNT; a grant scan tests each live grant.
// Wake grants each waiter that conflicts with no live grant, one result each.
// Reset clears the slot fill count and the registers, no clearing pass.
// A new transfer is taken while the last result waits in the output register.
`include "assert_macros.svh"
module lock_table_with_waiters_unit
  import ltw_pkg::*;
#(
  parameter int NODE_SLOTS = 64,
  parameter int GRANTS_PER_NODE = 8,
  parameter int WAITERS_PER_NODE = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  mode,
  input  logic [31:0] node_key,
  input  logic [7:0]  client,
  input  logic [2:0]  lock_mode,
  input  logic [31:0] grant_lease,
  input  logic [47:0] now_ms,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  status,
  output logic        conflict_free,
  output logic        woken_valid,
  output logic [7:0]  woken_client,
  output logic [2:0]  woken_mode,
  output logic        last,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  localparam int SW = $clog2(NODE_SLOTS);
  localparam int FW = $clog2(NODE_SLOTS + 1);
  localparam int GCW = $clog2(GRANTS_PER_NODE + 1);
  localparam int WCW = $clog2(WAITERS_PER_NODE + 1);
  localparam int GA_W = $clog2(NODE_SLOTS * GRANTS_PER_NODE);
  localparam int WA_W = $clog2(NODE_SLOTS * WAITERS_PER_NODE);
  localparam int RW = $clog2(MAX_RESULTS + 1);
  localparam int RIW = $clog2(MAX_RESULTS);
  localparam int CNT_W = GCW + WCW;

  state_t state, state_next;

  logic [MAT_W-1:0] compat_matrix;
  logic [LEASE_W-1:0] default_lease;

  logic [2:0] op;
  logic [31:0] key;
  logic [CLIENT_BITS-1:0] cli;
  logic [MODE_W-1:0] md;
  logic [LEASE_W-1:0] lease;
  logic [TIME_W-1:0] now;

  logic [FW-1:0] fill;
  logic [FW-1:0] idx;
  logic [SW-1:0] slot;
  logic [GCW-1:0] gcnt;
  logic [WCW-1:0] wcnt;
  logic [GCW-1:0] j;
  logic [WCW-1:0] wi;
  logic [RW-1:0] nres;
  logic [RW-1:0] eidx;
  logic [1:0] st;
  logic cf;
  logic [CLIENT_BITS-1:0] req_cli;
  logic [MODE_W-1:0] req_md;
  logic [CLIENT_BITS-1:0] res_cli [MAX_RESULTS];
  logic [MODE_W-1:0] res_md [MAX_RESULTS];

  logic [31:0] key_mem [NODE_SLOTS];
  logic [31:0] key_q;
  logic key_we;
  logic [SW-1:0] key_waddr, key_raddr;

  logic [CNT_W-1:0] cnt_mem [NODE_SLOTS];
  logic [CNT_W-1:0] cnt_q, cnt_wdata;
  logic cnt_we;

  grant_entry_t grant_mem [NODE_SLOTS * GRANTS_PER_NODE];
  grant_entry_t grant_q, grant_wdata;
  logic grant_we;
  logic [GA_W-1:0] grant_waddr, grant_raddr, gbase;

  waiter_entry_t wait_mem [NODE_SLOTS * WAITERS_PER_NODE];
  waiter_entry_t wait_q, wait_wdata;
  logic wait_we;
  logic [WA_W-1:0] wait_waddr, wait_raddr, wbase;

  logic cfg_wr;
  logic in_xfer;
  logic emit_go;
  logic node_full;
  logic gr_end;
  logic g_full, w_full;
  logic wk_end;
  logic rel_match;
  logic conflict;
  logic multi;
  logic emit_last;
  logic [LEASE_W-1:0] new_lease;
  logic [EXP_W-1:0] new_expiry;
  conf_req_t creq;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;
  assign prdata = (paddr[2] == REG_LEASE) ? default_lease : 32'(compat_matrix);

  always_ff @(posedge clk) begin
    if (rst) begin
      compat_matrix <= '0;
      default_lease <= '0;
    end else if (cfg_wr) begin
      if (paddr[2] == REG_COMPAT) begin
        compat_matrix <= pwdata[MAT_W-1:0];
      end else begin
        default_lease <= pwdata;
      end
    end
  end

  assign in_ready = (state == S_IDLE);
  assign in_xfer = in_valid && in_ready;
  assign emit_go = !out_valid || out_ready;
  assign node_full = (fill == FW'(NODE_SLOTS));
  assign gr_end = (j >= gcnt);
  assign g_full = (gcnt >= GCW'(GRANTS_PER_NODE));
  assign w_full = (wcnt >= WCW'(WAITERS_PER_NODE));
  assign wk_end = (wi >= wcnt) || (nres >= RW'(MAX_RESULTS));
  assign rel_match = (grant_q.cli == cli) && (grant_q.md == md);
  assign multi = (op == OP_WAKE) && (nres != '0);
  assign emit_last = !multi || (eidx == nres - 1'b1);
  assign gbase = GA_W'(slot) * GA_W'(GRANTS_PER_NODE);
  assign wbase = WA_W'(slot) * WA_W'(WAITERS_PER_NODE);
  assign new_lease = (op == OP_WAKE) ? default_lease : lease;
  assign new_expiry = (new_lease != '0) ? ({1'b0, now} + EXP_W'(new_lease)) : '0;

  assign creq = '{cli: req_cli, md: req_md, now: now, matrix: compat_matrix};

  ltw_conflict u_conflict (
    .grant(grant_q),
    .req(creq),
    .conflict(conflict)
  );

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_xfer) begin
          state_next = (mode > OP_WAKE) ? S_EMIT : S_LK_RD;
        end
      end
      S_LK_RD: begin
        if (idx == fill) begin
          state_next = node_full ? S_EMIT : S_CNT_RD;
        end else begin
          state_next = S_LK_CMP;
        end
      end
      S_LK_CMP: state_next = (key_q == key) ? S_CNT_RD : S_LK_RD;
      S_CNT_RD: state_next = S_CNT;
      S_CNT: state_next = S_DISP;
      S_DISP: begin
        unique case (op)
          OP_CHECK, OP_RELEASE: state_next = S_GR_RD;
          OP_GRANT: state_next = g_full ? S_EMIT : S_FIN;
          OP_ADD_WAITER: state_next = w_full ? S_EMIT : S_FIN;
          default: state_next = S_WK_RD;
        endcase
      end
      S_GR_RD: begin
        if (gr_end) begin
          priority case (op)
            OP_WAKE: state_next = S_WK_GRANT;
            default: state_next = S_EMIT;
          endcase
        end else begin
          state_next = S_GR_CMP;
        end
      end
      S_GR_CMP: begin
        priority case (op)
          OP_RELEASE: state_next = rel_match ? S_REL_RD : S_GR_RD;
          OP_CHECK: state_next = conflict ? S_EMIT : S_GR_RD;
          default: state_next = conflict ? S_WK_RD : S_GR_RD;
        endcase
      end
      S_REL_RD: state_next = S_REL_WR;
      S_REL_WR: state_next = S_FIN;
      S_WK_RD: state_next = wk_end ? S_FIN : S_WK_GET;
      S_WK_GET: state_next = S_GR_RD;
      S_WK_GRANT: state_next = g_full ? S_FIN : S_WK_LAST_RD;
      S_WK_LAST_RD: state_next = S_WK_LAST_WR;
      S_WK_LAST_WR: state_next = S_WK_RD;
      S_FIN: state_next = S_EMIT;
      S_EMIT: begin
        if (emit_go && emit_last) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    key_we = 1'b0;
    key_waddr = fill[SW-1:0];
    key_raddr = idx[SW-1:0];
    cnt_we = 1'b0;
    cnt_wdata = {gcnt, wcnt};
    grant_we = 1'b0;
    grant_waddr = gbase + GA_W'(gcnt);
    grant_wdata = '{cli: cli, md: md, expiry: new_expiry};
    grant_raddr = gbase + GA_W'(j);
    wait_we = 1'b0;
    wait_waddr = wbase + WA_W'(wcnt);
    wait_wdata = '{cli: cli, md: md};
    wait_raddr = wbase + WA_W'(wi);
    unique case (state)
      S_LK_RD: begin
        if ((idx == fill) && !node_full) begin
          key_we = 1'b1;
          cnt_we = 1'b1;
          cnt_wdata = '0;
        end
      end
      S_DISP: begin
        grant_we = (op == OP_GRANT) && !g_full;
        wait_we = (op == OP_ADD_WAITER) && !w_full;
      end
      S_REL_RD: grant_raddr = gbase + GA_W'(gcnt - 1'b1);
      S_REL_WR: begin
        grant_we = 1'b1;
        grant_waddr = gbase + GA_W'(j);
        grant_wdata = grant_q;
      end
      S_WK_GRANT: begin
        grant_we = !g_full;
        grant_wdata = '{cli: req_cli, md: req_md, expiry: new_expiry};
      end
      S_WK_LAST_RD: wait_raddr = wbase + WA_W'(wcnt - 1'b1);
      S_WK_LAST_WR: begin
        wait_we = 1'b1;
        wait_waddr = wbase + WA_W'(wi);
        wait_wdata = wait_q;
      end
      S_FIN: cnt_we = 1'b1;
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (key_we) begin
      key_mem[key_waddr] <= key;
    end
    key_q <= key_mem[key_raddr];
  end

  function automatic logic [SW-1:0] slot_wr_addr();
    logic [SW-1:0] a;
    a = (state == S_LK_RD) ? fill[SW-1:0] : slot;
    return a;
  endfunction

  always_ff @(posedge clk) begin
    if (cnt_we) begin
      cnt_mem[slot_wr_addr()] <= cnt_wdata;
    end
    cnt_q <= cnt_mem[slot];
  end

  always_ff @(posedge clk) begin
    if (grant_we) begin
      grant_mem[grant_waddr] <= grant_wdata;
    end
    grant_q <= grant_mem[grant_raddr];
  end

  always_ff @(posedge clk) begin
    if (wait_we) begin
      wait_mem[wait_waddr] <= wait_wdata;
    end
    wait_q <= wait_mem[wait_raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      fill <= '0;
      nres <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if ((state == S_EMIT) && emit_go) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_xfer) begin
            op <= mode;
            key <= node_key;
            cli <= client[CLIENT_BITS-1:0];
            md <= lock_mode;
            lease <= grant_lease;
            now <= now_ms;
            idx <= '0;
            nres <= '0;
            eidx <= '0;
            st <= ST_OK;
            cf <= 1'b1;
          end
        end
        S_LK_RD: begin
          if (idx == fill) begin
            if (node_full) begin
              st <= ST_FULL;
            end else begin
              slot <= fill[SW-1:0];
              fill <= fill + 1'b1;
            end
          end
        end
        S_LK_CMP: begin
          if (key_q == key) begin
            slot <= idx[SW-1:0];
          end else begin
            idx <= idx + 1'b1;
          end
        end
        S_CNT: begin
          gcnt <= cnt_q[CNT_W-1:WCW];
          wcnt <= cnt_q[WCW-1:0];
        end
        S_DISP: begin
          j <= '0;
          wi <= '0;
          req_cli <= cli;
          req_md <= md;
          unique case (op)
            OP_GRANT: begin
              if (g_full) st <= ST_FULL;
              else gcnt <= gcnt + 1'b1;
            end
            OP_ADD_WAITER: begin
              if (w_full) st <= ST_FULL;
              else wcnt <= wcnt + 1'b1;
            end
            default: begin
            end
          endcase
        end
        S_GR_RD: begin
          if (gr_end && (op == OP_RELEASE)) begin
            st <= ST_NOT_FOUND;
          end
        end
        S_GR_CMP: begin
          priority case (op)
            OP_RELEASE: begin
              if (!rel_match) j <= j + 1'b1;
            end
            OP_CHECK: begin
              if (conflict) cf <= 1'b0;
              else j <= j + 1'b1;
            end
            default: begin
              if (conflict) wi <= wi + 1'b1;
              else j <= j + 1'b1;
            end
          endcase
        end
        S_REL_WR: gcnt <= gcnt - 1'b1;
        S_WK_GET: begin
          req_cli <= wait_q.cli;
          req_md <= wait_q.md;
          j <= '0;
        end
        S_WK_GRANT: begin
          if (g_full) begin
            st <= ST_FULL;
          end else begin
            gcnt <= gcnt + 1'b1;
            res_cli[nres[RIW-1:0]] <= req_cli;
            res_md[nres[RIW-1:0]] <= req_md;
            nres <= nres + 1'b1;
          end
        end
        S_WK_LAST_WR: wcnt <= wcnt - 1'b1;
        S_EMIT: begin
          if (emit_go) begin
            status <= st;
            last <= emit_last;
            conflict_free <= (op == OP_CHECK) && (st == ST_OK) && cf;
            woken_valid <= multi;
            woken_client <= multi ? 8'(res_cli[eidx[RIW-1:0]]) : 8'd0;
            woken_mode <= multi ? res_md[eidx[RIW-1:0]] : 3'd0;
            eidx <= eidx + 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  `LTW_ASSERT(a_fill_bound, fill <= FW'(NODE_SLOTS), "slot fill count beyond table depth")
  `LTW_ASSERT_IMPL(a_gcnt, state == S_FIN, gcnt <= GCW'(GRANTS_PER_NODE), "grant count overflow")
  `LTW_ASSERT(a_result_bound, nres <= RW'(MAX_RESULTS), "more woken waiters than results allowed")
endmodule
